FILE: hw/rtl/qmi_pkg.sv
package qmi_pkg;

    localparam int DATA_W = 32;
    localparam int OCC_W  = 5;

    // request kinds
    typedef enum logic [1:0] {
        REQ_TAIL   = 2'd0,
        REQ_MIDDLE = 2'd1,
        REQ_POP    = 2'd2
    } req_t;

    // result status codes
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    // per-cell move control
    typedef struct packed {
        logic load_new;   // take the request value
        logic take_prev;  // take the left neighbor (shift back)
        logic take_next;  // take the right neighbor (shift forward)
    } cell_ctrl_t;

endpackage

FILE: hw/rtl/qmi_cell.sv
module qmi_cell
    import qmi_pkg::*;
(
    input  logic                     clk,
    input  cell_ctrl_t               ctrl,
    input  logic signed [DATA_W-1:0] new_data,
    input  logic signed [DATA_W-1:0] prev_data,
    input  logic signed [DATA_W-1:0] next_data,
    output logic signed [DATA_W-1:0] data
);

    logic signed [DATA_W-1:0] data_reg;
    logic signed [DATA_W-1:0] data_next;

    // at most one select is high in a cycle
    always_comb
    begin
        priority if (ctrl.load_new)
        begin
            data_next = new_data;
        end
        else if (ctrl.take_prev)
        begin
            data_next = prev_data;
        end
        else if (ctrl.take_next)
        begin
            data_next = next_data;
        end
        else
        begin
            data_next = data_reg;
        end
    end

    // storage, no reset: contents are valid only below the fill count
    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

FILE: hw/rtl/queue_with_middle_insert_core.sv
// Channel   Handshake            Payload
// in        in_valid/in_ready    req_type[1:0], value[31:0] signed
// out       out_valid/out_ready  popped_value[31:0] signed, status[1:0], occupancy[4:0]
//
// One request per cycle while in_ready is high; its result is registered and shows the cycle after the transfer.
// Every cell of the entry chain moves at once (insert, shift back, shift forward), so
// the cost of an insert or pop does not depend on its position.
// in_ready is high while the result register is empty or being drained this cycle.
// Reset clears the fill count and the result valid; entry contents are not reset.
module queue_with_middle_insert_core
    import qmi_pkg::*;
#(
    parameter int DEPTH = 16
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [1:0]               req_type,
    input  logic signed [DATA_W-1:0] value,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic signed [DATA_W-1:0] popped_value,
    output logic [1:0]               status,
    output logic [OCC_W-1:0]         occupancy
);

    localparam int CW = $clog2(DEPTH + 1);

    logic [CW-1:0]             count_reg;
    logic [CW-1:0]             count_next;
    logic                      out_valid_reg;
    logic                      out_valid_next;
    logic signed [DATA_W-1:0]  popped_reg;
    logic signed [DATA_W-1:0]  popped_next;
    status_t                   status_reg;
    status_t                   status_next;
    logic [OCC_W-1:0]          occ_reg;
    logic [OCC_W-1:0]          occ_next;

    logic                      in_fire;
    logic                      do_push;
    logic                      do_pop;
    logic [CW:0]               mid_sum;
    logic [CW-1:0]             pos;
    logic signed [DATA_W-1:0]  cell_data [DEPTH];
    cell_ctrl_t                cell_ctrl [DEPTH];

    assign in_ready = !out_valid_reg || out_ready;
    assign in_fire  = in_valid && in_ready;

    // insert position: tail at count, middle at ceil(count/2)
    assign mid_sum = {1'b0, count_reg} + {{CW{1'b0}}, 1'b1};
    assign pos     = (req_type == REQ_TAIL) ? count_reg : mid_sum[CW:1];

    // request decode, fill count and result
    always_comb
    begin
        do_push        = 1'b0;
        do_pop         = 1'b0;
        count_next     = count_reg;
        popped_next    = popped_reg;
        status_next    = status_reg;
        occ_next       = occ_reg;
        out_valid_next = out_valid_reg;
        if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (in_fire)
        begin
            out_valid_next = 1'b1;
            popped_next    = '0;
            status_next    = ST_OK;
            unique case (req_type)
                REQ_TAIL, REQ_MIDDLE:
                begin
                    if (count_reg == CW'(DEPTH))
                    begin
                        status_next = ST_FULL;
                    end
                    else
                    begin
                        do_push    = 1'b1;
                        count_next = count_reg + 1'b1;
                    end
                end
                REQ_POP:
                begin
                    if (count_reg == '0)
                    begin
                        status_next = ST_EMPTY;
                    end
                    else
                    begin
                        do_pop      = 1'b1;
                        popped_next = cell_data[0];
                        count_next  = count_reg - 1'b1;
                    end
                end
                default:
                begin
                    status_next = ST_OK;
                end
            endcase
            occ_next = OCC_W'(count_next);
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        popped_reg <= popped_next;
        status_reg <= status_next;
        occ_reg    <= occ_next;
    end

    // chain of entry cells, head at cell 0
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic signed [DATA_W-1:0] prev_d;
        logic signed [DATA_W-1:0] next_d;

        if (i == 0)
        begin : g_head
            assign prev_d = '0;
        end
        else
        begin : g_mid
            assign prev_d = cell_data[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_tail
            assign next_d = '0;
        end
        else
        begin : g_body
            assign next_d = cell_data[i+1];
        end

        assign cell_ctrl[i].load_new  = do_push && (CW'(i) == pos);
        assign cell_ctrl[i].take_prev = do_push && (CW'(i) > pos) && (CW'(i) <= count_reg);
        assign cell_ctrl[i].take_next = do_pop && (CW'(i + 1) < count_reg);

        qmi_cell u_cell (
            .clk       (clk),
            .ctrl      (cell_ctrl[i]),
            .new_data  (value),
            .prev_data (prev_d),
            .next_data (next_d),
            .data      (cell_data[i])
        );
    end

    assign out_valid    = out_valid_reg;
    assign popped_value = popped_reg;
    assign status       = status_reg;
    assign occupancy    = occ_reg;

    // checks
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("fill count above depth");

    a_pop_dec: assert property (@(posedge clk) disable iff (!rst_n)
        do_pop |=> count_reg == $past(count_reg) - 1'b1)
        else $error("pop did not decrement count");

    a_push_inc: assert property (@(posedge clk) disable iff (!rst_n)
        do_push |=> count_reg == $past(count_reg) + 1'b1)
        else $error("push did not increment count");

    a_refused_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && status_reg != ST_OK |-> popped_reg == '0)
        else $error("refused request returned data");

    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> in_ready)
        else $error("input stalled with empty result register");

endmodule

FILE: tb/sv/queue_with_middle_insert_checker.sv
// Watches both channels of the queue core, predicts every result and compares.
module queue_with_middle_insert_checker
    import qmi_pkg::*;
#(
    parameter int DEPTH = 16
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    input  logic                     in_ready,
    input  logic [1:0]               req_type,
    input  logic signed [DATA_W-1:0] value,
    input  logic                     out_valid,
    input  logic                     out_ready,
    input  logic signed [DATA_W-1:0] popped_value,
    input  logic [1:0]               status,
    input  logic [OCC_W-1:0]         occupancy,
    output int                       fail_count,
    output int                       outstanding
);

    typedef struct packed {
        logic signed [DATA_W-1:0] popped;
        status_t                  status;
        logic [OCC_W-1:0]         occupancy;
    } queue_result_t;

    // shadow copy of the queue, head at index 0
    logic signed [DATA_W-1:0] shadow_cells [DEPTH];
    int                       shadow_count;

    // results predicted but not yet seen on the output channel
    queue_result_t pending_results [$];

    initial
    begin
        fail_count  = 0;
        outstanding = 0;
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("[%0t] mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
        fail_count++;
    endtask

    // apply one request to the shadow queue and return its result
    task automatic apply_request(input logic [1:0] kind, input logic signed [DATA_W-1:0] data,
                                 output queue_result_t res);
        int slot;
        res.popped = '0;
        res.status = ST_OK;
        if (kind == REQ_TAIL || kind == REQ_MIDDLE)
        begin
            if (shadow_count >= DEPTH)
                res.status = ST_FULL;
            else
            begin
                // middle slot is ceil(count/2)
                slot = (kind == REQ_TAIL) ? shadow_count : (shadow_count + 1) / 2;
                for (int i = shadow_count; i > slot; i--)
                    shadow_cells[i] = shadow_cells[i-1];
                shadow_cells[slot] = data;
                shadow_count++;
            end
        end
        else if (kind == REQ_POP)
        begin
            if (shadow_count == 0)
                res.status = ST_EMPTY;
            else
            begin
                res.popped = shadow_cells[0];
                for (int i = 0; i + 1 < shadow_count; i++)
                    shadow_cells[i] = shadow_cells[i+1];
                shadow_count--;
            end
        end
        // unused kind: no change, ok status
        res.occupancy = shadow_count[OCC_W-1:0];
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        queue_result_t predicted;
        queue_result_t oldest;
        if (!rst_n)
        begin
            shadow_count = 0;
            pending_results.delete();
            outstanding = 0;
        end
        else
        begin
            // output transfer: checked against the oldest prediction
            if (out_valid && out_ready)
            begin
                if (pending_results.size() == 0)
                    report_mismatch("unexpected result", {30'd0, status}, '0);
                else
                begin
                    oldest = pending_results.pop_front();
                    if (popped_value !== oldest.popped)
                        report_mismatch("popped_value", popped_value, oldest.popped);
                    if (status !== oldest.status)
                        report_mismatch("status", {30'd0, status}, {30'd0, oldest.status});
                    if (occupancy !== oldest.occupancy)
                        report_mismatch("occupancy", {27'd0, occupancy},
                                        {27'd0, oldest.occupancy});
                end
            end
            // input transfer: predict its result
            if (in_valid && in_ready)
            begin
                apply_request(req_type, value, predicted);
                pending_results.push_back(predicted);
            end
            outstanding = pending_results.size();
        end
    end

endmodule

FILE: tb/sv/queue_with_middle_insert_core_tb.sv
module queue_with_middle_insert_core_tb;
    import qmi_pkg::*;

    localparam int         DEPTH       = 16;
    localparam int         CYCLE_LIMIT = 200000;
    localparam int         RANDOM_REQS = 1925;
    localparam logic [1:0] REQ_UNUSED  = 2'd3;

    logic                     clk       = 1'b0;
    logic                     rst_n     = 1'b0;
    logic                     in_valid  = 1'b0;
    logic                     in_ready;
    logic [1:0]               req_type  = REQ_TAIL;
    logic signed [DATA_W-1:0] value     = '0;
    logic                     out_valid;
    logic                     out_ready = 1'b0;
    logic signed [DATA_W-1:0] popped_value;
    logic [1:0]               status;
    logic [OCC_W-1:0]         occupancy;
    int                       fail_count;
    int                       outstanding;
    bit                       calm      = 1'b0;

    queue_with_middle_insert_core #(.DEPTH(DEPTH)) DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .req_type     (req_type),
        .value        (value),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .popped_value (popped_value),
        .status       (status),
        .occupancy    (occupancy)
    );

    queue_with_middle_insert_checker #(.DEPTH(DEPTH)) checker_i (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .req_type     (req_type),
        .value        (value),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .popped_value (popped_value),
        .status       (status),
        .occupancy    (occupancy),
        .fail_count   (fail_count),
        .outstanding  (outstanding)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // watchdog
    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("CHECKS FAILED");
        $finish;
    end

    // result side: random back-pressure, none during the calm stretch
    always @(negedge clk)
    begin
        out_ready <= rst_n && (calm || $urandom_range(99) >= 35);
    end

    // one request transfer, with random idle cycles ahead of it
    task automatic send_req(input logic [1:0] kind, input logic signed [DATA_W-1:0] data);
        @(negedge clk);
        while (!calm && $urandom_range(99) < 35)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        req_type <= kind;
        value    <= data;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    // stop sending and let every outstanding result drain
    task automatic drain_results();
        @(negedge clk);
        in_valid <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
    endtask

    // random data, with the extremes showing up now and then
    function automatic logic signed [DATA_W-1:0] pick_value();
        case ($urandom_range(39))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2:       return '0;
            3:       return '1;
            default: return $urandom;
        endcase
    endfunction

    // request kind, biased toward filling or draining the queue
    function automatic logic [1:0] pick_kind(input bit filling);
        int r;
        r = $urandom_range(99);
        if (r < 3)
            return REQ_UNUSED;
        if (filling)
            return (r < 40) ? REQ_TAIL : (r < 70) ? REQ_MIDDLE : REQ_POP;
        return (r < 20) ? REQ_TAIL : (r < 35) ? REQ_MIDDLE : REQ_POP;
    endfunction

    initial
    begin
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: empty pop, unused kind, middle into empty, odd/even middle slots
        send_req(REQ_POP, 32'h1234_5678);
        send_req(REQ_UNUSED, '1);
        send_req(REQ_MIDDLE, 32'h7fff_ffff);
        send_req(REQ_TAIL, 32'h8000_0000);
        send_req(REQ_MIDDLE, '1);
        send_req(REQ_MIDDLE, '0);
        send_req(REQ_POP, '0);
        // fill up, then push into a full queue both ways
        for (int i = 0; i < 13; i++)
            send_req(REQ_TAIL, $urandom);
        send_req(REQ_TAIL, 32'h5555_aaaa);
        send_req(REQ_MIDDLE, 32'haaaa_5555);
        send_req(REQ_UNUSED, '0);
        send_req(REQ_POP, '1);
        send_req(REQ_POP, '1);

        // random: alternating fill and drain stretches
        for (int i = 0; i < RANDOM_REQS; i++)
        begin
            calm = (i >= 600 && i < 900);
            if (i == 1200)
                drain_results();
            send_req(pick_kind((i / 48) % 2 == 0), pick_value());
        end
        calm = 1'b0;

        drain_results();
        repeat (4) @(negedge clk);
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
